// ===== src/bir_pkg.sv =====
// Shared constants, code values and interface structs for the bilinear resize unit.
// Depends on nothing; the mapper, the blender, the top level and the testbench import it.
package bir_pkg;

    localparam int MAX_COLS  = 256;
    localparam int MAX_ROWS  = 256;
    localparam int FRAC_BITS = 8;

    localparam int COORD_W     = 10;
    localparam int PIX_W       = 8;
    localparam int SIZE_W      = 9;
    localparam int STEP_W      = 24;
    localparam int STEP_FRAC_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam int POS_W       = COORD_W + STEP_W;
    localparam int POS_INT_W   = POS_W - STEP_FRAC_W;
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int BANK_ADDR_W = (ROW_W - 1) + (COL_W - 1);
    localparam int WGT_W       = FRAC_BITS + 1;
    localparam int HSUM_W      = PIX_W + FRAC_BITS;
    localparam int VSUM_W      = PIX_W + 2 * FRAC_BITS;
    localparam int PIPE_LAT    = 7;

    localparam logic [SIZE_W-1:0] SRC_COLS_RESET = SIZE_W'(256);
    localparam logic [SIZE_W-1:0] SRC_ROWS_RESET = SIZE_W'(256);
    localparam logic [STEP_W-1:0] STEP_RESET     = STEP_W'(26153);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_COLS = 2'd0,
        CFG_SRC_ROWS = 2'd1,
        CFG_STEP     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [SIZE_W-1:0] src_cols;
        logic [SIZE_W-1:0] src_rows;
        logic [STEP_W-1:0] step_q16;
    } cfg_t;

    // Output of the coordinate mapper. For a write, r0/c0 carry the write
    // address and wpix the pixel.
    typedef struct packed {
        logic                 valid;
        logic                 query;
        logic                 w_ok;
        logic [ROW_W-1:0]     r0;
        logic [ROW_W-1:0]     r1;
        logic [COL_W-1:0]     c0;
        logic [COL_W-1:0]     c1;
        logic [FRAC_BITS-1:0] fy;
        logic [FRAC_BITS-1:0] fx;
        logic [PIX_W-1:0]     wpix;
    } map_t;

    // What the blender needs to pick the four neighbours out of the banks.
    typedef struct packed {
        logic                 valid;
        logic                 r0p;
        logic                 r1p;
        logic                 c0p;
        logic                 c1p;
        logic [FRAC_BITS-1:0] fy;
        logic [FRAC_BITS-1:0] fx;
    } blend_ctrl_t;

endpackage

// ===== src/bir_bank.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for the four parity banks of the frame store; no package dependency.
module bir_bank #(
    parameter int ADDR_W = 14,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bir_mapper.sv =====
// Coordinate mapper: three register stages from request to clamped neighbour indices.
// Depends on bir_pkg for widths and the cfg_t / map_t structs.
module bir_mapper
    import bir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic               func,
    input  logic [COORD_W-1:0] row,
    input  logic [COORD_W-1:0] col,
    input  logic [PIX_W-1:0]   pixel,
    input  cfg_t               cfg,
    output map_t               map
);

    // Stage 1: captured request.
    logic               v1_reg;
    logic               q1_reg;
    logic [COORD_W-1:0] row1_reg;
    logic [COORD_W-1:0] col1_reg;
    logic [PIX_W-1:0]   pix1_reg;

    // Stage 2: source positions.
    logic               v2_reg;
    logic               q2_reg;
    logic [COORD_W-1:0] row2_reg;
    logic [COORD_W-1:0] col2_reg;
    logic [PIX_W-1:0]   pix2_reg;
    logic [POS_W-1:0]   pos_r2_reg;
    logic [POS_W-1:0]   pos_c2_reg;

    // Stage 3: indices.
    map_t map_reg;
    map_t map_next;

    logic [SIZE_W-1:0]    rows_m1;
    logic [SIZE_W-1:0]    cols_m1;
    logic [ROW_W-1:0]     last_row;
    logic [COL_W-1:0]     last_col;
    logic [POS_INT_W-1:0] ip_r;
    logic [POS_INT_W-1:0] ip_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            map_reg <= '0;
        end
        else
        begin
            v1_reg  <= accept;
            v2_reg  <= v1_reg;
            map_reg <= map_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q1_reg     <= func;
        row1_reg   <= row;
        col1_reg   <= col;
        pix1_reg   <= pixel;
        q2_reg     <= q1_reg;
        row2_reg   <= row1_reg;
        col2_reg   <= col1_reg;
        pix2_reg   <= pix1_reg;
        pos_r2_reg <= POS_W'(row1_reg) * POS_W'(cfg.step_q16);
        pos_c2_reg <= POS_W'(col1_reg) * POS_W'(cfg.step_q16);
    end

    always_comb
    begin
        // A size of zero acts as one; a size above the store acts as its maximum.
        rows_m1 = (cfg.src_rows == '0) ? '0 : cfg.src_rows - SIZE_W'(1);
        cols_m1 = (cfg.src_cols == '0) ? '0 : cfg.src_cols - SIZE_W'(1);
        last_row = (rows_m1 > SIZE_W'(MAX_ROWS - 1)) ? ROW_W'(MAX_ROWS - 1)
                                                     : ROW_W'(rows_m1);
        last_col = (cols_m1 > SIZE_W'(MAX_COLS - 1)) ? COL_W'(MAX_COLS - 1)
                                                     : COL_W'(cols_m1);

        ip_r = pos_r2_reg[POS_W-1:STEP_FRAC_W];
        ip_c = pos_c2_reg[POS_W-1:STEP_FRAC_W];

        map_next.valid = v2_reg;
        map_next.query = (q2_reg == FUNC_QUERY);
        map_next.w_ok  = (row2_reg < COORD_W'(MAX_ROWS)) && (col2_reg < COORD_W'(MAX_COLS));
        map_next.wpix  = pix2_reg;
        map_next.fy    = pos_r2_reg[STEP_FRAC_W-1 -: FRAC_BITS];
        map_next.fx    = pos_c2_reg[STEP_FRAC_W-1 -: FRAC_BITS];

        if (q2_reg == FUNC_QUERY)
        begin
            map_next.r0 = (ip_r > POS_INT_W'(last_row)) ? last_row : ROW_W'(ip_r);
            map_next.r1 = (ip_r >= POS_INT_W'(last_row)) ? last_row
                                                         : ROW_W'(ip_r) + ROW_W'(1);
            map_next.c0 = (ip_c > POS_INT_W'(last_col)) ? last_col : COL_W'(ip_c);
            map_next.c1 = (ip_c >= POS_INT_W'(last_col)) ? last_col
                                                         : COL_W'(ip_c) + COL_W'(1);
        end
        else
        begin
            map_next.r0 = ROW_W'(row2_reg);
            map_next.r1 = ROW_W'(row2_reg);
            map_next.c0 = COL_W'(col2_reg);
            map_next.c1 = COL_W'(col2_reg);
        end
    end

    assign map = map_reg;

`ifndef SYNTH
    // The banked read relies on floor+1 being either the next index or the clamp.
    assert property (@(posedge clk) disable iff (!rst_n)
        map_reg.valid && map_reg.query |->
            (map_reg.r1 == map_reg.r0) || (map_reg.r1 == map_reg.r0 + ROW_W'(1)))
        else $error("row neighbours are not adjacent");
    assert property (@(posedge clk) disable iff (!rst_n)
        map_reg.valid && map_reg.query |->
            (map_reg.c1 == map_reg.c0) || (map_reg.c1 == map_reg.c0 + COL_W'(1)))
        else $error("column neighbours are not adjacent");
    assert property (@(posedge clk) disable iff (!rst_n)
        map_reg.valid && map_reg.query |->
            (map_reg.r0 <= map_reg.r1) && (map_reg.c0 <= map_reg.c1))
        else $error("floor neighbour lies beyond the floor+1 neighbour");
`endif

endmodule

// ===== src/bir_blend.sv =====
// Two-axis blender: selects the neighbours from the banks, then weights, sums and rounds.
// Depends on bir_pkg for widths and the blend_ctrl_t struct.
module bir_blend
    import bir_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  blend_ctrl_t       ctrl,
    input  logic [PIX_W-1:0]  bank_q [4],
    output logic              done,
    output logic [PIX_W-1:0]  value
);

    localparam int RND_W = VSUM_W + 1;

    blend_ctrl_t ctrl_reg;

    logic              v5_reg;
    logic [HSUM_W-1:0] top_reg;
    logic [HSUM_W-1:0] bot_reg;
    logic [WGT_W-1:0]  wy5_reg;
    logic [WGT_W-1:0]  fy5_reg;
    logic [HSUM_W-1:0] top_next;
    logic [HSUM_W-1:0] bot_next;

    logic              v6_reg;
    logic [VSUM_W-1:0] pa_reg;
    logic [VSUM_W-1:0] pb_reg;

    logic              done_reg;
    logic [PIX_W-1:0]  value_reg;
    logic [PIX_W-1:0]  value_next;

    logic [PIX_W-1:0]  p00;
    logic [PIX_W-1:0]  p01;
    logic [PIX_W-1:0]  p10;
    logic [PIX_W-1:0]  p11;
    logic [WGT_W-1:0]  wx;
    logic [RND_W-1:0]  rnd;
    logic [RND_W-2*FRAC_BITS-1:0] scaled;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl;
            v5_reg   <= ctrl_reg.valid;
            v6_reg   <= v5_reg;
            done_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        bot_reg      <= bot_next;
        wy5_reg      <= WGT_W'(1 << FRAC_BITS) - WGT_W'(ctrl_reg.fy);
        fy5_reg      <= WGT_W'(ctrl_reg.fy);
        pa_reg       <= VSUM_W'(top_reg) * VSUM_W'(wy5_reg);
        pb_reg       <= VSUM_W'(bot_reg) * VSUM_W'(fy5_reg);
        value_reg    <= value_next;
    end

    always_comb
    begin
        // Bank index is {row parity, column parity}.
        p00 = bank_q[{ctrl_reg.r0p, ctrl_reg.c0p}];
        p01 = bank_q[{ctrl_reg.r0p, ctrl_reg.c1p}];
        p10 = bank_q[{ctrl_reg.r1p, ctrl_reg.c0p}];
        p11 = bank_q[{ctrl_reg.r1p, ctrl_reg.c1p}];
        wx  = WGT_W'(1 << FRAC_BITS) - WGT_W'(ctrl_reg.fx);

        top_next = HSUM_W'(p00) * HSUM_W'(wx) + HSUM_W'(p01) * HSUM_W'(ctrl_reg.fx);
        bot_next = HSUM_W'(p10) * HSUM_W'(wx) + HSUM_W'(p11) * HSUM_W'(ctrl_reg.fx);

        rnd = RND_W'(pa_reg) + RND_W'(pb_reg) + RND_W'(1 << (2 * FRAC_BITS - 1));
        scaled = rnd[RND_W-1:2*FRAC_BITS];
        value_next = (scaled > (RND_W-2*FRAC_BITS)'(255)) ? PIX_W'(255) : PIX_W'(scaled);
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

// ===== src/bilinear_image_resize_unit.sv =====
// Top level of the bilinear image resize unit: configuration registers, frame store banks.
// Depends on bir_pkg, bir_mapper, bir_bank and bir_blend.
//
//   Channel   Direction  Handshake                 Payload
//   request   in         start && !busy            func, row, col, pixel
//   result    out        done, one cycle           value
//   config    in         cfg_we                    cfg_index, cfg_data
//
// One request is taken every clock cycle; busy is never raised.
// A query's result is on value with done high once the request has passed the
// mapper and blender stages; a write gives no result. Four row/column parity banks
// let the four neighbours of a query be read together, which sets the rate.
// Reset loads the configuration defaults and clears the valid bits; the frame store is undefined until written.
// The receiver cannot stall, so the pipeline never holds.
module bilinear_image_resize_unit
    import bir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  func,
    input  logic [COORD_W-1:0]    row,
    input  logic [COORD_W-1:0]    col,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  done,
    output logic [PIX_W-1:0]      value
);

    cfg_t        cfg_reg;
    map_t        map;
    blend_ctrl_t ctrl;
    logic        accept;
    logic [PIX_W-1:0] bank_q [4];

    // The pipeline is never blocked, so every request is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration registers. Writes to an index beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_cols <= SRC_COLS_RESET;
            cfg_reg.src_rows <= SRC_ROWS_RESET;
            cfg_reg.step_q16 <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SRC_COLS: cfg_reg.src_cols <= cfg_data[SIZE_W-1:0];
                CFG_SRC_ROWS: cfg_reg.src_rows <= cfg_data[SIZE_W-1:0];
                CFG_STEP:     cfg_reg.step_q16 <= cfg_data[STEP_W-1:0];
                default:      ;
            endcase
        end
    end

    // Stages one to three: capture, multiply by the step, clamp the indices.
    bir_mapper u_mapper (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .func   (func),
        .row    (row),
        .col    (col),
        .pixel  (pixel),
        .cfg    (cfg_reg),
        .map    (map)
    );

    // Four parity banks. Floor and floor+1 differ in parity unless clamped to
    // the same index, so each bank serves at most one distinct neighbour.
    // Writes and reads are issued at the same stage, keeping their order.
    for (genvar rp = 0; rp < 2; rp++)
    begin : g_bank_row
        for (genvar cp = 0; cp < 2; cp++)
        begin : g_bank_col
            logic [ROW_W-1:0]       rsel;
            logic [COL_W-1:0]       csel;
            logic                   bank_we;
            logic [BANK_ADDR_W-1:0] waddr;
            logic [BANK_ADDR_W-1:0] raddr;

            assign rsel    = (map.r0[0] == 1'(rp)) ? map.r0 : map.r1;
            assign csel    = (map.c0[0] == 1'(cp)) ? map.c0 : map.c1;
            assign bank_we = map.valid && !map.query && map.w_ok
                             && (map.r0[0] == 1'(rp)) && (map.c0[0] == 1'(cp));
            assign waddr   = {map.r0[ROW_W-1:1], map.c0[COL_W-1:1]};
            assign raddr   = {rsel[ROW_W-1:1], csel[COL_W-1:1]};

            bir_bank #(
                .ADDR_W (BANK_ADDR_W),
                .DATA_W (PIX_W)
            ) u_bank (
                .clk   (clk),
                .we    (bank_we),
                .waddr (waddr),
                .wdata (map.wpix),
                .raddr (raddr),
                .rdata (bank_q[2 * rp + cp])
            );
        end
    end

    // The blender registers this alongside the bank read data.
    always_comb
    begin
        ctrl.valid = map.valid && map.query;
        ctrl.r0p   = map.r0[0];
        ctrl.r1p   = map.r1[0];
        ctrl.c0p   = map.c0[0];
        ctrl.c1p   = map.c1[0];
        ctrl.fy    = map.fy;
        ctrl.fx    = map.fx;
    end

    // Stages four to seven: neighbour select and horizontal blend, vertical
    // products, sum with rounding and saturation into the output register.
    bir_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .bank_q (bank_q),
        .done   (done),
        .value  (value)
    );

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == FUNC_QUERY) |-> ##PIPE_LAT done)
        else $error("query request produced no result");
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && (func == FUNC_WRITE) |-> ##PIPE_LAT !done)
        else $error("write request produced a result");
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised although the pipeline never holds");
`endif

endmodule

// ===== tb/sv/bilinear_image_resize_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bilinear_image_resize_unit: a directed stimulus table, then random
// pixel writes and queries checked against a behavioural blend predictor. Depends on bir_pkg.
module bilinear_image_resize_unit_tb
    import bir_pkg::*;
();

    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 400000;
    localparam int COORD_TOP   = (1 << COORD_W) - 1;

    // The register index that names no register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_WRITE,
        ROW_QUERY
    } row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [COORD_W-1:0]    r;
        logic [COORD_W-1:0]    c;
        logic [PIX_W-1:0]      px;
        bit                    pinned;
        logic [PIX_W-1:0]      want;
    } script_row_t;

    // Neighbour indices and weight along one axis of the source image.
    typedef struct packed {
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] frac;
    } axis_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  func      = FUNC_WRITE;
    logic [COORD_W-1:0]    row       = '0;
    logic [COORD_W-1:0]    col       = '0;
    logic [PIX_W-1:0]      pixel     = '0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SRC_COLS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  done;
    logic [PIX_W-1:0]      value;

    // A typed-in expectation travels beside the request it belongs to, so that the
    // result watcher picks it up at the very edge at which the request is taken.
    logic                  pin_valid = 1'b0;
    logic [PIX_W-1:0]      pin_value = '0;

    // Shadow of the block as seen by the result watcher.
    logic [PIX_W-1:0]      image [MAX_ROWS][MAX_COLS];
    logic [SIZE_W-1:0]     cols_m = SRC_COLS_RESET;
    logic [SIZE_W-1:0]     rows_m = SRC_ROWS_RESET;
    logic [STEP_W-1:0]     step_m = STEP_RESET;
    logic [PIX_W-1:0]      pending_pixels [$];

    // What the stimulus side has written so far; kept apart from the shadow above so
    // that it never reads state that the watcher updates at the same edge.
    bit                    loaded [MAX_ROWS][MAX_COLS];
    logic [SIZE_W-1:0]     cols_s = SRC_COLS_RESET;
    logic [SIZE_W-1:0]     rows_s = SRC_ROWS_RESET;
    logic [STEP_W-1:0]     step_s = STEP_RESET;
    bit                    burst_mode = 1'b0;
    int unsigned           counted = 0;

    int unsigned           errors = 0;
    int unsigned           cycles = 0;
    script_row_t           script [$];

    bilinear_image_resize_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .func      (func),
        .row       (row),
        .col       (col),
        .pixel     (pixel),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .value     (value)
    );

    always #5 clk = ~clk;

    // The run is abandoned if it has not finished within the limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t ns: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("bilinear_image_resize_unit_tb: errors");
            $finish;
        end
    end

    // Last usable index of an axis: a size of zero behaves as one, and sizes above
    // the store's extent behave as that extent.
    function automatic int unsigned last_index(logic [SIZE_W-1:0] size, int unsigned max_size);
        int unsigned last;
        last = (size == 0) ? 0 : int'(size) - 1;
        if (last > max_size - 1)
            last = max_size - 1;
        return last;
    endfunction

    // Target coordinate to source position: floor and floor+1, both clamped to the
    // last index, and the top FRAC_BITS of the Q.16 fraction as the weight.
    function automatic axis_t map_axis(logic [COORD_W-1:0] coord, logic [STEP_W-1:0] step,
                                       logic [SIZE_W-1:0] size, int unsigned max_size);
        logic [POS_W-1:0] pos;
        longint unsigned  ip;
        longint unsigned  last;
        axis_t            a;
        pos    = POS_W'(coord) * POS_W'(step);
        ip     = longint'(pos >> STEP_FRAC_W);
        last   = last_index(size, max_size);
        a.lo   = 16'((ip > last) ? last : ip);
        a.hi   = 16'((ip + 1 > last) ? last : ip + 1);
        a.frac = 16'(pos[STEP_FRAC_W-1 -: FRAC_BITS]);
        return a;
    endfunction

    // Expected pixel for a query, from the watcher's shadow of store and registers.
    function automatic logic [PIX_W-1:0] blend_pixel(logic [COORD_W-1:0] r,
                                                     logic [COORD_W-1:0] c);
        axis_t       ay;
        axis_t       ax;
        int unsigned s;
        int unsigned top;
        int unsigned bot;
        int unsigned sum;
        int unsigned v;
        ay  = map_axis(r, step_m, rows_m, MAX_ROWS);
        ax  = map_axis(c, step_m, cols_m, MAX_COLS);
        s   = 1 << FRAC_BITS;
        top = image[ay.lo][ax.lo] * (s - ax.frac) + image[ay.lo][ax.hi] * ax.frac;
        bot = image[ay.hi][ax.lo] * (s - ax.frac) + image[ay.hi][ax.hi] * ax.frac;
        sum = top * (s - ay.frac) + bot * ay.frac;
        v   = (sum + (1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        if (v > 255)
            v = 255;
        return PIX_W'(v);
    endfunction

    // Result watcher. Everything is sampled at the rising edge, so the values seen
    // are those the block itself took at that edge. Results are compared first,
    // then the shadow is brought up to date with any register write or request.
    always @(posedge clk)
    begin : result_watch
        logic [PIX_W-1:0] oldest;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_pixels.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %0d",
                             $time, value);
                end
                else
                begin
                    oldest = pending_pixels.pop_front();
                    if (value !== oldest)
                    begin
                        errors++;
                        $display("%0t ns: value mismatch, expected %0d, actual %0d",
                                 $time, oldest, value);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SRC_COLS: cols_m = cfg_data[SIZE_W-1:0];
                    CFG_SRC_ROWS: rows_m = cfg_data[SIZE_W-1:0];
                    CFG_STEP:     step_m = cfg_data[STEP_W-1:0];
                    default:      ;
                endcase
            end
            if (start && !busy)
            begin
                if (func == FUNC_WRITE)
                begin
                    // Writes outside the store are dropped by the block.
                    if (row < MAX_ROWS && col < MAX_COLS)
                        image[row[ROW_W-1:0]][col[COL_W-1:0]] = pixel;
                end
                else
                begin
                    pending_pixels.push_back(pin_valid ? pin_value : blend_pixel(row, col));
                end
            end
        end
    end

    // Drives one request and holds it until the block takes it, then idles for a
    // random number of cycles unless the current stretch runs without gaps. A
    // request that follows with no gap keeps start high rather than toggling it.
    task automatic issue_request(logic f, logic [COORD_W-1:0] r, logic [COORD_W-1:0] c,
                                 logic [PIX_W-1:0] px, bit pinned, logic [PIX_W-1:0] want);
        int unsigned gap;
        start     <= 1'b1;
        func      <= f;
        row       <= r;
        col       <= c;
        pixel     <= px;
        pin_valid <= pinned;
        pin_value <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (r < MAX_ROWS && c < MAX_COLS)
        begin
            counted++;
            if (f == FUNC_WRITE)
                loaded[r[ROW_W-1:0]][c[COL_W-1:0]] = 1'b1;
        end
        else if (f == FUNC_QUERY)
        begin
            counted++;
        end
        gap = burst_mode ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Registers change only with the block idle. A write leaves no result behind,
    // so after the last result the pipeline depth is allowed to run out as well.
    task automatic settle();
        start <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SRC_COLS: cols_s = data[SIZE_W-1:0];
            CFG_SRC_ROWS: rows_s = data[SIZE_W-1:0];
            CFG_STEP:     step_s = data[STEP_W-1:0];
            default:      ;
        endcase
        @(posedge clk);
    endtask

    task automatic put_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        script_row_t s;
        s      = '{kind: ROW_CFG, default: '0};
        s.idx  = idx;
        s.data = data;
        script.push_back(s);
    endtask

    task automatic put_write(int r, int c, int px);
        script_row_t s;
        s    = '{kind: ROW_WRITE, default: '0};
        s.r  = COORD_W'(r);
        s.c  = COORD_W'(c);
        s.px = PIX_W'(px);
        script.push_back(s);
    endtask

    task automatic put_query(int r, int c, bit pinned, int want);
        script_row_t s;
        s        = '{kind: ROW_QUERY, default: '0};
        s.r      = COORD_W'(r);
        s.c      = COORD_W'(c);
        s.pinned = pinned;
        s.want   = PIX_W'(want);
        script.push_back(s);
    endtask

    // Sizes are mostly small so that the random queries revisit the same pixels;
    // now and then the extremes, including values the block must clamp.
    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return SIZE_W'($urandom_range(2, 12));
        if (roll == 7)
            return SIZE_W'(MAX_COLS);
        if (roll == 8)
            return SIZE_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return SIZE_W'(0);
            1:       return SIZE_W'(1);
            2:       return SIZE_W'(2);
            default: return '1;
        endcase
    endfunction

    // Usually the step a real resize would use, (src-1)/(tgt-1); otherwise the
    // extremes or arbitrary values that drive positions past the image edge.
    function automatic logic [STEP_W-1:0] pick_step();
        int unsigned     roll;
        longint unsigned tgt;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return '0;
            1:       return '1;
            2, 3:    return STEP_W'($urandom);
            4:       return STEP_W'($urandom_range(0, 32'h20000));
            default:
            begin
                tgt = $urandom_range(2, COORD_TOP + 1);
                return STEP_W'((longint'(last_index(cols_s, MAX_COLS)) << STEP_FRAC_W)
                               / (tgt - 1));
            end
        endcase
    endfunction

    // A target coordinate that mostly lands inside the source image, with the
    // odd one anywhere in the field so that edge replication is exercised.
    function automatic logic [COORD_W-1:0] pick_coord(logic [SIZE_W-1:0] size,
                                                      int unsigned max_size);
        int unsigned     roll;
        longint unsigned span;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '1;
        if (roll == 1)
            return '0;
        if (step_s == 0 || roll == 2)
            return COORD_W'($urandom_range(0, COORD_TOP));
        span = (longint'(last_index(size, max_size) + 1) << STEP_FRAC_W) / step_s;
        if (span > COORD_TOP)
            span = COORD_TOP;
        return COORD_W'($urandom_range(0, int'(span)));
    endfunction

    initial
    begin
        logic [CFG_DATA_W-1:0] data;
        logic [COORD_W-1:0]    qr;
        logic [COORD_W-1:0]    qc;
        axis_t                 ay;
        axis_t                 ax;
        int unsigned           nr;
        int unsigned           nc;
        int unsigned           roll;
        int unsigned           phase_len;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the reset values of the registers in force at first.
        // The four corner pixels form a white block; writes outside the store, at the
        // first coordinate past each edge and at the field maxima, must not land on it.
        put_write(0, 0, 255);
        put_write(0, 1, 255);
        put_write(1, 0, 255);
        put_write(1, 1, 255);
        put_write(MAX_ROWS, 0, 0);
        put_write(0, MAX_COLS, 0);
        put_write(COORD_TOP, COORD_TOP, 0);
        put_write(MAX_ROWS - 1, MAX_COLS - 1, 170);
        put_query(0, 0, 1'b1, 255);
        // Far beyond the image: all four neighbours replicate the last pixel.
        put_query(COORD_TOP, COORD_TOP, 1'b1, 170);
        put_query(1, 1, 1'b0, 0);
        // Half-pixel step: a black/white pair blends to the rounding midpoint.
        put_cfg(CFG_STEP, 24'h008000);
        put_write(0, 1, 0);
        put_query(0, 1, 1'b0, 0);
        put_query(1, 0, 1'b0, 0);
        // Zero step maps every target onto the first pixel.
        put_cfg(CFG_STEP, 24'h000000);
        put_query(COORD_TOP, COORD_TOP, 1'b1, 255);
        put_cfg(CFG_SPARE, 24'hFFFFFF);
        put_query(COORD_TOP, 0, 1'b1, 255);
        // Sizes of zero behave as one; the upper data bits of a size write are dropped.
        put_cfg(CFG_STEP, 24'hFFFFFF);
        put_cfg(CFG_SRC_COLS, 24'hFFFE00);
        put_cfg(CFG_SRC_ROWS, 24'h000000);
        put_query(COORD_TOP, COORD_TOP, 1'b1, 255);
        put_query(0, 0, 1'b1, 255);
        // Oversized width clamps to the store; a height of two rows.
        put_cfg(CFG_SRC_COLS, 24'h0001FF);
        put_cfg(CFG_SRC_ROWS, 24'h000002);
        put_cfg(CFG_STEP, 24'h010000);
        put_query(0, 0, 1'b1, 255);
        put_query(5, 0, 1'b0, 0);

        foreach (script[i])
        begin
            case (script[i].kind)
                ROW_CFG:
                begin
                    settle();
                    write_reg(script[i].idx, script[i].data);
                end
                ROW_WRITE:
                    issue_request(FUNC_WRITE, script[i].r, script[i].c, script[i].px, 1'b0, '0);
                default:
                    issue_request(FUNC_QUERY, script[i].r, script[i].c, PIX_W'($urandom),
                                  script[i].pinned, script[i].want);
            endcase
        end

        // Random part, in phases. Each phase waits for the block to drain, which is
        // also where the sender holds off until every result is in, then sets all
        // three registers afresh and sends a run of requests.
        while (counted < ITEM_TARGET)
        begin
            settle();
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
            data = CFG_DATA_W'($urandom);
            data[SIZE_W-1:0] = pick_size();
            write_reg(CFG_SRC_COLS, data);
            data = CFG_DATA_W'($urandom);
            data[SIZE_W-1:0] = pick_size();
            write_reg(CFG_SRC_ROWS, data);
            write_reg(CFG_STEP, pick_step());

            burst_mode = ($urandom_range(0, 3) == 0);
            phase_len  = $urandom_range(30, 120);
            for (int k = 0; k < phase_len && counted < ITEM_TARGET; k++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    // A query is preceded by writes of any neighbour not yet loaded,
                    // so that no entry is ever read before it is written.
                    qr = pick_coord(rows_s, MAX_ROWS);
                    qc = pick_coord(cols_s, MAX_COLS);
                    ay = map_axis(qr, step_s, rows_s, MAX_ROWS);
                    ax = map_axis(qc, step_s, cols_s, MAX_COLS);
                    for (int i = 0; i < 2; i++)
                    begin
                        for (int j = 0; j < 2; j++)
                        begin
                            nr = (i == 0) ? ay.lo : ay.hi;
                            nc = (j == 0) ? ax.lo : ax.hi;
                            if (!loaded[nr][nc])
                                issue_request(FUNC_WRITE, COORD_W'(nr), COORD_W'(nc),
                                              PIX_W'($urandom), 1'b0, '0);
                        end
                    end
                    issue_request(FUNC_QUERY, qr, qc, PIX_W'($urandom), 1'b0, '0);
                end
                else if (roll < 80)
                begin
                    issue_request(FUNC_WRITE,
                                  COORD_W'($urandom_range(0, last_index(rows_s, MAX_ROWS))),
                                  COORD_W'($urandom_range(0, last_index(cols_s, MAX_COLS))),
                                  PIX_W'($urandom), 1'b0, '0);
                end
                else if (roll < 90)
                begin
                    issue_request(FUNC_WRITE, COORD_W'($urandom_range(0, MAX_ROWS - 1)),
                                  COORD_W'($urandom_range(0, MAX_COLS - 1)),
                                  PIX_W'($urandom), 1'b0, '0);
                end
                else
                begin
                    // A write that misses the store on at least one axis.
                    qr = COORD_W'($urandom_range(0, COORD_TOP));
                    qc = COORD_W'($urandom_range(0, COORD_TOP));
                    if (qr < MAX_ROWS && qc < MAX_COLS)
                    begin
                        if ($urandom_range(0, 1) == 0)
                            qr = COORD_W'($urandom_range(MAX_ROWS, COORD_TOP));
                        else
                            qc = COORD_W'($urandom_range(MAX_COLS, COORD_TOP));
                    end
                    issue_request(FUNC_WRITE, qr, qc, PIX_W'($urandom), 1'b0, '0);
                end
            end
        end

        settle();
        if (pending_pixels.size() != 0)
        begin
            errors++;
            $display("%0t ns: %0d results still outstanding at the end",
                     $time, pending_pixels.size());
        end
        if (errors == 0)
            $display("bilinear_image_resize_unit_tb: clean");
        else
            $display("bilinear_image_resize_unit_tb: errors");
        $finish;
    end

endmodule
